// ----- hdl/swsf_pkg.sv -----
// Shared types and constants for the sliding-window sender with fast retransmit.
`default_nettype none
package swsf_pkg;

   localparam int unsigned MSG_BYTES     = 16;  // bytes per message, power of two
   localparam int unsigned MSG_SHIFT     = $clog2(MSG_BYTES);
   localparam int unsigned DUP_ACK_LIMIT = 3;

   localparam logic [1:0]  KIND_SEND    = 2'd0;
   localparam logic [1:0]  KIND_ACK     = 2'd1;
   localparam logic [1:0]  KIND_TIMEOUT = 2'd2;

   localparam logic [15:0] WINDOW_RESET = 16'd64;
   localparam logic [31:0] SEQ_RESET    = 32'd1;
   localparam logic [15:0] COUNT_FULL   = 16'hFFFF;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] ack_number;
      logic        ack_checksum_ok;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        transmit_valid;
      logic [31:0] transmit_seq;
      logic        is_retransmit;
      logic        timer_start;
      logic        timer_stop;
   } rsp_type;

   typedef struct packed {
      logic [31:0] next_sequence;
      logic [31:0] window_base;
      logic [31:0] oldest_unacked;
      logic [15:0] outstanding_count;
      logic        timer_running;
      logic [1:0]  duplicate_count;
   } state_type;

endpackage
`default_nettype wire

// ----- hdl/sliding_window_sender_fast_retransmit.sv -----
// Sliding-window sender control: cumulative ACKs, timeout and fast retransmit.
// An accepted req beat passes the input register, then the result register,
// to become its rsp beat. Throughput: one beat per cycle unless rsp_stall holds
// it; the state update is a single pass of compare/add/shift logic between them.
// Reset (synchronous, active high) sets window_limit to 64, sequence registers
// to 1, counts and timer flag to 0, and empties both pipeline registers.
`default_nettype none
module sliding_window_sender_fast_retransmit (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire swsf_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output swsf_pkg::rsp_type      rsp_data,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire [15:0]             csr_data
);

   logic                s1_valid_ff, s1_valid_in;
   swsf_pkg::req_type   s1_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   swsf_pkg::rsp_type   rsp_data_ff;
   swsf_pkg::state_type state_ff, state_in;
   logic [15:0]         limit_ff, limit_in;
   swsf_pkg::rsp_type   rsp_calc;
   logic                advance;
   logic                s1_move;

   swsf_update u_update (
      .cur          (state_ff),
      .item         (s1_data_ff),
      .window_limit (limit_ff),
      .nxt          (state_in),
      .rsp          (rsp_calc)
   );

   // result register frees up when empty or being taken this cycle
   assign advance      = !rsp_valid_ff || !rsp_stall;
   assign s1_move      = s1_valid_ff && advance;
   assign req_stall    = s1_valid_ff && !advance;
   assign s1_valid_in  = (req_valid && !req_stall) || (s1_valid_ff && !advance);
   assign rsp_valid_in = s1_valid_ff || (rsp_valid_ff && rsp_stall);
   assign csr_ready    = !s1_valid_ff;
   assign limit_in     = (csr_valid && csr_ready) ? csr_data : limit_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff              <= 1'b0;
         rsp_valid_ff             <= 1'b0;
         limit_ff                 <= swsf_pkg::WINDOW_RESET;
         state_ff.next_sequence   <= swsf_pkg::SEQ_RESET;
         state_ff.window_base     <= swsf_pkg::SEQ_RESET;
         state_ff.oldest_unacked  <= swsf_pkg::SEQ_RESET;
         state_ff.outstanding_count <= 16'd0;
         state_ff.timer_running   <= 1'b0;
         state_ff.duplicate_count <= 2'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         limit_ff     <= limit_in;
         if (s1_move) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_data_ff <= req_data;
      end
      if (s1_move) begin
         rsp_data_ff <= rsp_calc;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/swsf_update.sv -----
// Per-beat state update and result generation for the window sender.
`default_nettype none
module swsf_update (
   input  wire swsf_pkg::state_type  cur,
   input  wire swsf_pkg::req_type    item,
   input  wire logic [15:0]          window_limit,
   output swsf_pkg::state_type       nxt,
   output swsf_pkg::rsp_type         rsp
);

   logic [31:0] win_edge;
   logic [31:0] send_diff;
   logic        send_beyond;
   logic [31:0] ack_diff;
   logic        ack_adv;
   logic [31:0] pop_diff;
   logic        pop_ok;
   logic [32:0] pop_raw;
   logic [15:0] pops;
   logic [15:0] cnt_left;
   logic [31:0] oldest_pop;
   logic [1:0]  dup_inc;

   always_comb begin
      win_edge    = cur.window_base + {16'd0, window_limit};
      send_diff   = cur.next_sequence - win_edge;
      send_beyond = (send_diff != 32'd0) && !send_diff[31];

      ack_diff = item.ack_number - cur.window_base;
      ack_adv  = (ack_diff != 32'd0) && !ack_diff[31];

      // messages retired: ceil((ack - oldest) / MSG_BYTES), capped at the count
      pop_diff = item.ack_number - cur.oldest_unacked;
      pop_ok   = (pop_diff != 32'd0) && !pop_diff[31];
      pop_raw  = ({1'b0, pop_diff} + 33'(swsf_pkg::MSG_BYTES - 1)) >> swsf_pkg::MSG_SHIFT;
      if (!pop_ok) begin
         pops = 16'd0;
      end else if (pop_raw > {17'd0, cur.outstanding_count}) begin
         pops = cur.outstanding_count;
      end else begin
         pops = pop_raw[15:0];
      end
      cnt_left   = cur.outstanding_count - pops;
      oldest_pop = cur.oldest_unacked + ({16'd0, pops} << swsf_pkg::MSG_SHIFT);
      dup_inc    = cur.duplicate_count + 2'd1;

      nxt = cur;
      rsp = '0;
      case (item.kind)
         swsf_pkg::KIND_SEND: begin
            if (!send_beyond && cur.outstanding_count != swsf_pkg::COUNT_FULL) begin
               rsp.accepted       = 1'b1;
               rsp.transmit_valid = 1'b1;
               rsp.transmit_seq   = cur.next_sequence;
               if (cur.outstanding_count == 16'd0) begin
                  nxt.oldest_unacked = cur.next_sequence;
               end
               nxt.outstanding_count = cur.outstanding_count + 16'd1;
               if (!cur.timer_running) begin
                  rsp.timer_start   = 1'b1;
                  nxt.timer_running = 1'b1;
               end
               nxt.next_sequence = cur.next_sequence + 32'(swsf_pkg::MSG_BYTES);
            end
         end
         swsf_pkg::KIND_ACK: begin
            if (item.ack_checksum_ok) begin
               if (ack_adv) begin
                  nxt.window_base     = item.ack_number;
                  nxt.duplicate_count = 2'd0;
                  rsp.timer_stop      = cur.timer_running;
                  nxt.timer_running   = 1'b0;
                  nxt.outstanding_count = cnt_left;
                  if (cnt_left == 16'd0) begin
                     nxt.oldest_unacked = cur.next_sequence;
                  end else begin
                     nxt.oldest_unacked = oldest_pop;
                     rsp.timer_start    = 1'b1;
                     nxt.timer_running  = 1'b1;
                  end
               end else if (ack_diff == 32'd0) begin
                  nxt.duplicate_count = dup_inc;
                  if (dup_inc == 2'(swsf_pkg::DUP_ACK_LIMIT)) begin
                     nxt.duplicate_count = 2'd0;
                     if (cur.outstanding_count != 16'd0) begin
                        rsp.transmit_valid = 1'b1;
                        rsp.transmit_seq   = cur.oldest_unacked;
                        rsp.is_retransmit  = 1'b1;
                     end
                  end
               end
            end
         end
         swsf_pkg::KIND_TIMEOUT: begin
            if (cur.outstanding_count != 16'd0) begin
               rsp.transmit_valid = 1'b1;
               rsp.transmit_seq   = cur.oldest_unacked;
               rsp.is_retransmit  = 1'b1;
               rsp.timer_start    = 1'b1;
               nxt.timer_running  = 1'b1;
            end else begin
               nxt.timer_running = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- verif/sliding_window_sender_fast_retransmit_test.sv -----
// Testbench for the sliding-window sender: directed and random beats checked against a built-in predictor.
`timescale 1ns / 1ps

class window_scoreboard;
   swsf_pkg::state_type sender;
   logic [15:0]         window_limit;
   swsf_pkg::rsp_type   rsp_due[$];
   int                  errors;
   int                  n_beats, n_sent, n_refused, n_retx, n_stops;

   function new();
      sender.next_sequence     = swsf_pkg::SEQ_RESET;
      sender.window_base       = swsf_pkg::SEQ_RESET;
      sender.oldest_unacked    = swsf_pkg::SEQ_RESET;
      sender.outstanding_count = '0;
      sender.timer_running     = 1'b0;
      sender.duplicate_count   = '0;
      window_limit             = swsf_pkg::WINDOW_RESET;
   endfunction

   // serial-number order: a is after b within half the sequence space
   function bit seq_after(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d != 0 && !d[31];
   endfunction

   function void note_request(swsf_pkg::req_type r);
      swsf_pkg::rsp_type e;
      logic [31:0]       edge_seq, span;
      logic [32:0]       pops;
      e = '0;
      n_beats++;
      case (r.kind)
         swsf_pkg::KIND_SEND: begin
            edge_seq = sender.window_base + {16'd0, window_limit};
            if (!seq_after(sender.next_sequence, edge_seq) &&
                sender.outstanding_count != swsf_pkg::COUNT_FULL) begin
               e.accepted       = 1'b1;
               e.transmit_valid = 1'b1;
               e.transmit_seq   = sender.next_sequence;
               if (sender.outstanding_count == 0)
                  sender.oldest_unacked = sender.next_sequence;
               sender.outstanding_count++;
               if (!sender.timer_running) begin
                  e.timer_start        = 1'b1;
                  sender.timer_running = 1'b1;
               end
               sender.next_sequence += swsf_pkg::MSG_BYTES;
               n_sent++;
            end else begin
               n_refused++;
            end
         end
         swsf_pkg::KIND_ACK: begin
            if (r.ack_checksum_ok) begin
               if (seq_after(r.ack_number, sender.window_base)) begin
                  sender.window_base     = r.ack_number;
                  sender.duplicate_count = '0;
                  e.timer_stop           = sender.timer_running;
                  sender.timer_running   = 1'b0;
                  if (sender.outstanding_count != 0 &&
                      seq_after(sender.window_base, sender.oldest_unacked)) begin
                     span = sender.window_base - sender.oldest_unacked;
                     // a partly covered message counts as retired
                     pops = ({1'b0, span} + 33'(swsf_pkg::MSG_BYTES) - 33'd1)
                            / 33'(swsf_pkg::MSG_BYTES);
                     if (pops > 33'(sender.outstanding_count))
                        pops = 33'(sender.outstanding_count);
                     sender.outstanding_count -= pops[15:0];
                     sender.oldest_unacked += pops[31:0] * swsf_pkg::MSG_BYTES;
                  end
                  if (sender.outstanding_count == 0) begin
                     sender.oldest_unacked = sender.next_sequence;
                  end else begin
                     e.timer_start        = 1'b1;
                     sender.timer_running = 1'b1;
                  end
               end else if (r.ack_number == sender.window_base) begin
                  sender.duplicate_count = sender.duplicate_count + 2'd1;
                  if (sender.duplicate_count == swsf_pkg::DUP_ACK_LIMIT) begin
                     sender.duplicate_count = '0;
                     if (sender.outstanding_count != 0) begin
                        e.transmit_valid = 1'b1;
                        e.transmit_seq   = sender.oldest_unacked;
                        e.is_retransmit  = 1'b1;
                     end
                  end
               end
            end
         end
         swsf_pkg::KIND_TIMEOUT: begin
            if (sender.outstanding_count != 0) begin
               e.transmit_valid     = 1'b1;
               e.transmit_seq       = sender.oldest_unacked;
               e.is_retransmit      = 1'b1;
               e.timer_start        = 1'b1;
               sender.timer_running = 1'b1;
            end else begin
               sender.timer_running = 1'b0;
            end
         end
         default: ;
      endcase
      if (e.is_retransmit) n_retx++;
      if (e.timer_stop) n_stops++;
      rsp_due.insert(rsp_due.size(), e);
   endfunction

   function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= 100)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endfunction

   function void check_response(swsf_pkg::rsp_type got);
      swsf_pkg::rsp_type e;
      if (rsp_due.size() == 0) begin
         errors++;
         $display("%0t: unexpected rsp beat, expected none, actual %0h", $time, got);
         return;
      end
      e = rsp_due[0];
      rsp_due.delete(0);
      compare_field("accepted", 32'(e.accepted), 32'(got.accepted));
      compare_field("transmit_valid", 32'(e.transmit_valid), 32'(got.transmit_valid));
      compare_field("transmit_seq", e.transmit_seq, got.transmit_seq);
      compare_field("is_retransmit", 32'(e.is_retransmit), 32'(got.is_retransmit));
      compare_field("timer_start", 32'(e.timer_start), 32'(got.timer_start));
      compare_field("timer_stop", 32'(e.timer_stop), 32'(got.timer_stop));
   endfunction
endclass

module sliding_window_sender_fast_retransmit_test;

   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   swsf_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   swsf_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [15:0]       csr_data;

   window_scoreboard window_sb = new();
   bit quiet_req, quiet_rsp;
   int window_writes;

   sliding_window_sender_fast_retransmit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // unused fields get random content
   function automatic swsf_pkg::req_type kind_beat(logic [1:0] k);
      swsf_pkg::req_type r;
      r.kind            = k;
      r.ack_number      = $urandom;
      r.ack_checksum_ok = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic swsf_pkg::req_type ack_beat(logic [31:0] n, logic ok);
      swsf_pkg::req_type r;
      r.kind            = swsf_pkg::KIND_ACK;
      r.ack_number      = n;
      r.ack_checksum_ok = ok;
      return r;
   endfunction

   // ACKs, the largest share of beats, mostly placed around the current base so the window keeps moving
   function automatic swsf_pkg::req_type random_req();
      logic [31:0] base, span, n;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return kind_beat(swsf_pkg::KIND_SEND);
      if (pick >= 97) return kind_beat(KIND_UNUSED);
      if (pick >= 85) return kind_beat(swsf_pkg::KIND_TIMEOUT);
      base = window_sb.sender.window_base;
      span = window_sb.sender.next_sequence - base;
      pick = $urandom_range(0, 99);
      if (pick < 30)
         n = (span != 0 && !span[31]) ? base + $urandom_range(1, span)
                                      : base + $urandom_range(1, 64);
      else if (pick < 40)
         n = window_sb.sender.oldest_unacked + swsf_pkg::MSG_BYTES * $urandom_range(1, 4);
      else if (pick < 70)
         n = base;
      else if (pick < 80)
         n = base - $urandom_range(1, 4096);
      else if (pick < 86)
         n = window_sb.sender.next_sequence + $urandom_range(1, 32'h0010_0000);
      else
         n = $urandom;
      return ack_beat(n, $urandom_range(0, 9) != 0);
   endfunction

   task automatic send_req(input swsf_pkg::req_type r);
      int gap;
      gap = quiet_req ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      window_sb.note_request(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (window_sb.rsp_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_window(input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      window_sb.window_limit = value;
      window_writes++;
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [15:0] value, input int items);
      drain();
      write_window(value);
      for (int i = 0; i < items; i++) begin
         if (i % 100 == 0) begin
            quiet_req = $urandom_range(0, 3) == 0;
            quiet_rsp = $urandom_range(0, 3) == 0;
         end
         send_req(random_req());
      end
   endtask

   initial begin
      int hold;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         hold = quiet_rsp ? 0 : $urandom_range(0, 11);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         window_sb.check_response(rsp_data);
      end
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: window at its reset value
      repeat (3) send_req(kind_beat(swsf_pkg::KIND_SEND));
      send_req(kind_beat(swsf_pkg::KIND_TIMEOUT));
      repeat (swsf_pkg::DUP_ACK_LIMIT)
         send_req(ack_beat(window_sb.sender.window_base, 1'b1));
      send_req(ack_beat(window_sb.sender.window_base + 32'd8, 1'b1));   // partial message
      send_req(ack_beat(window_sb.sender.window_base - 32'd1, 1'b1));   // old
      send_req(ack_beat(window_sb.sender.window_base + 32'd16, 1'b0));  // bad checksum
      send_req(kind_beat(KIND_UNUSED));
      repeat (4) send_req(kind_beat(swsf_pkg::KIND_SEND));              // hits window edge
      send_req(ack_beat(window_sb.sender.next_sequence, 1'b1));         // retire all
      send_req(kind_beat(swsf_pkg::KIND_TIMEOUT));                      // nothing outstanding
      send_req(ack_beat(window_sb.sender.window_base + 32'h7FFF_FFFF, 1'b1));
      send_req(ack_beat(window_sb.sender.window_base + 32'h8000_0000, 1'b1));
      send_req(ack_beat(32'hFFFF_FFFF, 1'b1));
      send_req(ack_beat(32'h0000_0000, 1'b1));
      send_req(kind_beat(swsf_pkg::KIND_SEND));
      send_req(kind_beat(swsf_pkg::KIND_TIMEOUT));

      run_phase(16'd1, 300);
      run_phase(16'hFFFF, 300);
      run_phase(swsf_pkg::WINDOW_RESET, 300);
      run_phase(16'($urandom_range(1, 65535)), 300);
      run_phase(16'(swsf_pkg::MSG_BYTES), 300);
      run_phase(16'($urandom_range(1, 1024)), 300);

      drain();
      repeat (16) @(posedge clock);
      $display("Covered %0d beats under %0d window settings: %0d sends, %0d refused.",
               window_sb.n_beats, window_writes, window_sb.n_sent, window_sb.n_refused);
      $display("Saw %0d retransmissions and %0d timer stops; %0d mismatches.",
               window_sb.n_retx, window_sb.n_stops, window_sb.errors);
      if (window_sb.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/swsf_pkg.sv
hdl/swsf_update.sv
hdl/sliding_window_sender_fast_retransmit.sv
verif/sliding_window_sender_fast_retransmit_test.sv
